[src/sorted_deadline_timer_pool_assert.svh]
// Assertion macros for the timer pool checker
`ifndef SORTED_DEADLINE_TIMER_POOL_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_POOL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SDTP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sdtp check failed");

// Next-cycle implication, sampled on clk, off during reset
`define SDTP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sdtp check failed");

`endif

[src/sdtp_pkg.sv]
// Shared types and codes for the sorted deadline timer pool
`timescale 1ns / 1ps
package sdtp_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int KW            = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_INIT  = 3'd2;
    localparam logic [2:0] ACT_SET   = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;

    localparam logic [1:0] KIND_GRANT   = 2'd0;
    localparam logic [1:0] KIND_FAIL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] pay;
        logic [3:0]  chan;
        logic        last;
    } res_t;

endpackage

[src/sorted_deadline_timer_pool.sv]
// Timer pool: fixed count 0 after reset, all slots free; no store clearing pass.
// Alloc, init and idle ticks: busy stays low, next item may follow in the next cycle.
// Alloc result shows in the cycle after the transfer.
// Free/set timeout: walks the sorted list, then reloads the earliest deadline;
// re-arming a running slot walks twice, once to unlink and once to insert.
// Expiring tick: pops expired slots, at most MAX_RESULTS; results one per step.
`timescale 1ns / 1ps
module sorted_deadline_timer_pool import sdtp_pkg::*; #(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         action,
    input  logic [3:0]         slot_id,
    input  logic [31:0]        timeout_ticks,
    input  logic signed [31:0] payload,
    input  logic [3:0]         channel,
    output logic               busy,
    output logic               valid,
    output logic [1:0]         kind,
    output logic [3:0]         slot_out,
    output logic signed [31:0] expired_payload,
    output logic [3:0]         expired_channel,
    output logic               last
);

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int LW = $clog2(TIMER_SLOTS + 1);
    localparam int DW = 32 + LW;

    res_t res;
    logic a_we, b_we;
    logic [SW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [DW-1:0] a_wdata, a_rdata;
    logic [35:0] b_wdata, b_rdata;

    // deadline and next link per slot
    sdtp_ram #(.WIDTH(DW), .DEPTH(TIMER_SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // payload and channel per slot
    sdtp_ram #(.WIDTH(36), .DEPTH(TIMER_SLOTS)) u_pay_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sdtp_engine #(.TIMER_SLOTS(TIMER_SLOTS)) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .slot_id       (slot_id),
        .timeout_ticks (timeout_ticks),
        .payload       (payload),
        .channel       (channel),
        .busy          (busy),
        .res           (res),
        .a_we          (a_we),
        .a_waddr       (a_waddr),
        .a_wdata       (a_wdata),
        .a_raddr       (a_raddr),
        .a_rdata       (a_rdata),
        .b_we          (b_we),
        .b_waddr       (b_waddr),
        .b_wdata       (b_wdata),
        .b_raddr       (b_raddr),
        .b_rdata       (b_rdata)
    );

    assign valid           = res.valid;
    assign kind            = res.kind;
    assign slot_out        = res.slot;
    assign expired_payload = res.pay;
    assign expired_channel = res.chan;
    assign last            = res.last;

endmodule

[src/sdtp_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module sdtp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/sdtp_engine.sv]
// Sequencer: slot marks, sorted list walks and expiry over the slot RAMs
`timescale 1ns / 1ps
module sdtp_engine import sdtp_pkg::*; #(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT,
    localparam int SW = $clog2(TIMER_SLOTS),
    localparam int LW = $clog2(TIMER_SLOTS + 1),
    localparam int DW = 32 + LW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [2:0]    action,
    input  logic [3:0]    slot_id,
    input  logic [31:0]   timeout_ticks,
    input  logic [31:0]   payload,
    input  logic [3:0]    channel,
    output logic          busy,
    output res_t          res,
    output logic          a_we,
    output logic [SW-1:0] a_waddr,
    output logic [DW-1:0] a_wdata,
    output logic [SW-1:0] a_raddr,
    input  logic [DW-1:0] a_rdata,
    output logic          b_we,
    output logic [SW-1:0] b_waddr,
    output logic [35:0]   b_wdata,
    output logic [SW-1:0] b_raddr,
    input  logic [35:0]   b_rdata
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_UL_RD  = 12'b0000_0000_0010,
        S_UL_CHK = 12'b0000_0000_0100,
        S_UL_END = 12'b0000_0000_1000,
        S_IN_RD  = 12'b0000_0001_0000,
        S_IN_CHK = 12'b0000_0010_0000,
        S_IN_WR  = 12'b0000_0100_0000,
        S_IN_LK  = 12'b0000_1000_0000,
        S_RF_RD  = 12'b0001_0000_0000,
        S_RF_CHK = 12'b0010_0000_0000,
        S_EX_RD  = 12'b0100_0000_0000,
        S_EX_CHK = 12'b1000_0000_0000
    } state_t;

    localparam logic [LW-1:0] NO_LINK = LW'(TIMER_SLOTS);

    state_t state_reg, state_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] earliest_reg, earliest_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [TIMER_SLOTS-1:0] free_reg, free_next;
    logic [TIMER_SLOTS-1:0] run_reg, run_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic prev_none_reg, prev_none_next;
    logic [31:0] prev_dl_reg, prev_dl_next;
    logic [LW-1:0] n_reg, n_next;
    logic [SW-1:0] s_reg, s_next;
    logic [2:0] op_reg, op_next;
    logic [31:0] dnew_reg, dnew_next;
    logic [KW-1:0] k_reg, k_next;
    logic ex_end_reg, ex_end_next;
    res_t pend_reg, pend_next;
    res_t res_reg, res_next;

    logic [31:0] rd_dl;
    logic [LW-1:0] rd_link;
    logic [SW-1:0] s_in;
    logic slot_ok;
    logic [SW-1:0] grant;
    logic found;
    logic [31:0] tick_inc;

    assign rd_dl    = a_rdata[DW-1:LW];
    assign rd_link  = a_rdata[LW-1:0];
    assign s_in     = SW'(slot_id);
    assign slot_ok  = int'(slot_id) < TIMER_SLOTS;
    assign tick_inc = tick_reg + 32'd1;
    assign busy     = (state_reg != S_IDLE) || ex_end_reg;
    assign res      = res_reg;

    // lowest free slot
    always_comb
    begin
        grant = '0;
        found = 1'b0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                grant = SW'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        earliest_next  = earliest_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        run_next       = run_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_none_next = prev_none_reg;
        prev_dl_next   = prev_dl_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        op_next        = op_reg;
        dnew_next      = dnew_reg;
        k_next         = k_reg;
        ex_end_next    = 1'b0;
        pend_next      = pend_reg;
        res_next       = '0;
        a_we           = 1'b0;
        a_waddr        = s_reg;
        a_wdata        = {dnew_reg, cur_reg};
        a_raddr        = cur_reg[SW-1:0];
        b_we           = 1'b0;
        b_waddr        = s_in;
        b_wdata        = {payload, channel};
        b_raddr        = head_reg[SW-1:0];

        if (ex_end_reg)
        begin
            // flush the held result as the final one, then refresh the head
            if (pend_reg.valid)
            begin
                res_next      = pend_reg;
                res_next.last = 1'b1;
            end
            pend_next.valid = 1'b0;
            if (count_reg == '0)
            begin
                head_next = '0;
            end
            state_next = S_RF_RD;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (action)
                            ACT_ALLOC:
                            begin
                                res_next.valid = 1'b1;
                                res_next.last  = 1'b1;
                                if (found)
                                begin
                                    free_next[grant] = 1'b0;
                                    res_next.kind    = KIND_GRANT;
                                    res_next.slot    = 4'(grant);
                                end
                                else
                                begin
                                    res_next.kind = KIND_FAIL;
                                end
                            end
                            ACT_FREE, ACT_SET:
                            begin
                                if (slot_ok)
                                begin
                                    s_next         = s_in;
                                    op_next        = action;
                                    dnew_next      = timeout_ticks + tick_reg;
                                    cur_next       = head_reg;
                                    prev_none_next = 1'b1;
                                    n_next         = '0;
                                    if (run_reg[s_in])
                                    begin
                                        state_next = S_UL_RD;
                                    end
                                    else if (action == ACT_FREE)
                                    begin
                                        free_next[s_in] = 1'b1;
                                    end
                                    else
                                    begin
                                        state_next = S_IN_RD;
                                    end
                                end
                            end
                            ACT_INIT:
                            begin
                                b_we = slot_ok;
                            end
                            ACT_TICK:
                            begin
                                tick_next = tick_inc;
                                if (!(earliest_reg > tick_inc))
                                begin
                                    k_next          = '0;
                                    pend_next.valid = 1'b0;
                                    state_next      = S_EX_RD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_UL_RD:
                begin
                    if (n_reg < count_reg && cur_reg < NO_LINK)
                    begin
                        state_next = S_UL_CHK;
                    end
                    else
                    begin
                        state_next = S_UL_END;
                    end
                end
                S_UL_CHK:
                begin
                    if (cur_reg == LW'(s_reg))
                    begin
                        if (prev_none_reg)
                        begin
                            head_next = rd_link;
                        end
                        else
                        begin
                            a_we    = 1'b1;
                            a_waddr = prev_reg;
                            a_wdata = {prev_dl_reg, rd_link};
                        end
                        count_next = count_reg - 1'b1;
                        state_next = S_UL_END;
                    end
                    else
                    begin
                        prev_next      = cur_reg[SW-1:0];
                        prev_none_next = 1'b0;
                        prev_dl_next   = rd_dl;
                        cur_next       = rd_link;
                        n_next         = n_reg + 1'b1;
                        state_next     = S_UL_RD;
                    end
                end
                S_UL_END:
                begin
                    run_next[s_reg] = 1'b0;
                    if (op_reg == ACT_FREE)
                    begin
                        free_next[s_reg] = 1'b1;
                        state_next       = S_RF_RD;
                    end
                    else
                    begin
                        cur_next       = head_reg;
                        prev_none_next = 1'b1;
                        n_next         = '0;
                        state_next     = S_IN_RD;
                    end
                end
                S_IN_RD:
                begin
                    if (n_reg < count_reg && cur_reg < NO_LINK)
                    begin
                        state_next = S_IN_CHK;
                    end
                    else
                    begin
                        if (!(n_reg < count_reg))
                        begin
                            cur_next = NO_LINK;
                        end
                        state_next = S_IN_WR;
                    end
                end
                S_IN_CHK:
                begin
                    // ties go ahead of equal deadlines
                    if (dnew_reg <= rd_dl)
                    begin
                        state_next = S_IN_WR;
                    end
                    else
                    begin
                        prev_next      = cur_reg[SW-1:0];
                        prev_none_next = 1'b0;
                        prev_dl_next   = rd_dl;
                        cur_next       = rd_link;
                        n_next         = n_reg + 1'b1;
                        state_next     = S_IN_RD;
                    end
                end
                S_IN_WR:
                begin
                    a_we             = 1'b1;
                    count_next       = count_reg + 1'b1;
                    run_next[s_reg]  = 1'b1;
                    free_next[s_reg] = 1'b0;
                    if (prev_none_reg)
                    begin
                        head_next  = LW'(s_reg);
                        state_next = S_RF_RD;
                    end
                    else
                    begin
                        state_next = S_IN_LK;
                    end
                end
                S_IN_LK:
                begin
                    a_we       = 1'b1;
                    a_waddr    = prev_reg;
                    a_wdata    = {prev_dl_reg, LW'(s_reg)};
                    state_next = S_RF_RD;
                end
                S_RF_RD:
                begin
                    a_raddr = head_reg[SW-1:0];
                    if (count_reg != '0 && head_reg < NO_LINK)
                    begin
                        state_next = S_RF_CHK;
                    end
                    else
                    begin
                        earliest_next = NO_DEADLINE;
                        state_next    = S_IDLE;
                    end
                end
                S_RF_CHK:
                begin
                    earliest_next = rd_dl;
                    state_next    = S_IDLE;
                end
                S_EX_RD:
                begin
                    a_raddr = head_reg[SW-1:0];
                    if (k_reg < KW'(MAX_RESULTS) && count_reg != '0 && head_reg < NO_LINK)
                    begin
                        state_next = S_EX_CHK;
                    end
                    else
                    begin
                        ex_end_next = 1'b1;
                    end
                end
                S_EX_CHK:
                begin
                    if (rd_dl > tick_reg)
                    begin
                        ex_end_next = 1'b1;
                    end
                    else
                    begin
                        // hold each result one step so the final one can carry last
                        if (pend_reg.valid)
                        begin
                            res_next = pend_reg;
                        end
                        pend_next.valid = 1'b1;
                        pend_next.kind  = KIND_EXPIRED;
                        pend_next.slot  = 4'(head_reg[SW-1:0]);
                        pend_next.pay   = b_rdata[35:4];
                        pend_next.chan  = b_rdata[3:0];
                        pend_next.last  = 1'b0;
                        run_next[head_reg[SW-1:0]] = 1'b0;
                        head_next  = rd_link;
                        count_next = count_reg - 1'b1;
                        k_next     = k_reg + 1'b1;
                        state_next = S_EX_RD;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            earliest_reg  <= NO_DEADLINE;
            head_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            run_reg       <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            prev_none_reg <= 1'b1;
            prev_dl_reg   <= '0;
            n_reg         <= '0;
            s_reg         <= '0;
            op_reg        <= ACT_ALLOC;
            dnew_reg      <= '0;
            k_reg         <= '0;
            ex_end_reg    <= 1'b0;
            pend_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            earliest_reg  <= earliest_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            run_reg       <= run_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            prev_none_reg <= prev_none_next;
            prev_dl_reg   <= prev_dl_next;
            n_reg         <= n_next;
            s_reg         <= s_next;
            op_reg        <= op_next;
            dnew_reg      <= dnew_next;
            k_reg         <= k_next;
            ex_end_reg    <= ex_end_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
        end
    end

endmodule

[src/sdtp_checker.sv]
// Port-level checks for the timer pool, bound to the top level
`timescale 1ns / 1ps
`include "sorted_deadline_timer_pool_assert.svh"
module sdtp_checker import sdtp_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic [2:0]         action,
    input logic [3:0]         slot_id,
    input logic [31:0]        timeout_ticks,
    input logic signed [31:0] payload,
    input logic [3:0]         channel,
    input logic               busy,
    input logic               valid,
    input logic [1:0]         kind,
    input logic [3:0]         slot_out,
    input logic signed [31:0] expired_payload,
    input logic [3:0]         expired_channel,
    input logic               last
);

    `SDTP_ASSERT_NEXT(a_alloc_answer, start && !busy && action == ACT_ALLOC, valid && last && kind != KIND_EXPIRED)
    `SDTP_ASSERT_NEXT(a_quiet_cmds, start && !busy && (action == ACT_FREE || action == ACT_INIT || action == ACT_SET), !valid)
    `SDTP_ASSERT_NOW(a_alloc_single, valid && kind != KIND_EXPIRED, last)
    `SDTP_ASSERT_NOW(a_fail_zero, valid && kind == KIND_FAIL, slot_out == 4'd0 && expired_payload == 32'sd0 && expired_channel == 4'd0)

endmodule

bind sorted_deadline_timer_pool sdtp_checker u_sdtp_checker (.*);
